[rtl/cfq_pkg.sv]
`timescale 1ns / 1ps

package cfq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_DUMP = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic       wr_push;
        logic       rd_head;
        logic       rd_dump_start;
        logic       rd_dump_next;
        logic       load_out;
        logic [1:0] out_status;
        logic       out_from_mem;
        logic       out_last;
    } cfq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic dump_done;
        logic out_free;
    } cfq_sts_t;

endpackage

[rtl/cfq_ctrl.sv]
`timescale 1ns / 1ps

module cfq_ctrl
    import cfq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  cfq_sts_t   sts,
    output cfq_cmd_t   cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   dump_reg;
    logic   dump_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dump_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            dump_reg  <= dump_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        dump_next  = dump_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = sts.out_free;
                if (s_valid && sts.out_free) begin
                    unique case (s_opcode)
                        OP_PUSH: begin
                            cmd.load_out = 1'b1;
                            cmd.out_last = 1'b1;
                            if (sts.full) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.out_status = ST_OK;
                                cmd.wr_push    = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (sts.empty) begin
                                cmd.load_out   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                                cmd.out_last   = 1'b1;
                            end else begin
                                cmd.rd_head = 1'b1;
                                dump_next   = 1'b0;
                                state_next  = S_EMIT;
                            end
                        end
                        OP_DUMP: begin
                            if (sts.empty) begin
                                cmd.load_out   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                                cmd.out_last   = 1'b1;
                            end else begin
                                cmd.rd_dump_start = 1'b1;
                                dump_next         = 1'b1;
                                state_next        = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_out     = 1'b1;
                    cmd.out_status   = ST_OK;
                    cmd.out_from_mem = 1'b1;
                    cmd.out_last     = !dump_reg || sts.dump_done;
                    if (dump_reg && !sts.dump_done) begin
                        cmd.rd_dump_next = 1'b1;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/cfq_datapath.sv]
`timescale 1ns / 1ps

module cfq_datapath
    import cfq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [31:0] s_push_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_data_out,
    output logic               m_last,
    input  cfq_cmd_t           cmd,
    output cfq_sts_t           sts
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        if (idx == LAST_IDX) begin
            res = '0;
        end else begin
            res = idx + AW'(1);
        end
        return res;
    endfunction

    logic signed [31:0] mem [DEPTH];

    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      head_next;
    logic [AW-1:0]      tail_reg;
    logic [AW-1:0]      tail_next;
    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      ptr_next;
    logic signed [31:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;

    logic               valid_reg;
    logic               valid_next;
    logic [1:0]         status_reg;
    logic signed [31:0] data_reg;
    logic               last_reg;

    assign rd_en   = cmd.rd_head || cmd.rd_dump_start || cmd.rd_dump_next;
    assign rd_addr = cmd.rd_dump_next ? ptr_reg : head_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_push) begin
            mem[tail_reg] <= s_push_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        ptr_next  = ptr_reg;
        if (cmd.wr_push) begin
            tail_next = next_idx(tail_reg);
        end
        if (cmd.rd_head) begin
            head_next = next_idx(head_reg);
        end
        if (cmd.rd_dump_start) begin
            ptr_next = next_idx(head_reg);
        end else if (cmd.rd_dump_next) begin
            ptr_next = next_idx(ptr_reg);
        end
    end

    assign valid_next = cmd.load_out || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            ptr_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ptr_reg   <= ptr_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            status_reg <= cmd.out_status;
            data_reg   <= cmd.out_from_mem ? rd_data_reg : 32'sd0;
            last_reg   <= cmd.out_last;
        end
    end

    assign sts.full      = (head_reg == next_idx(tail_reg));
    assign sts.empty     = (head_reg == tail_reg);
    assign sts.dump_done = (ptr_reg == tail_reg);
    assign sts.out_free  = !valid_reg || m_ready;

    assign m_valid    = valid_reg;
    assign m_status   = status_reg;
    assign m_data_out = data_reg;
    assign m_last     = last_reg;

endmodule

[rtl/circular_fifo_queue.sv]
`timescale 1ns / 1ps

// Ring-buffer queue of signed 32-bit values with DEPTH slots, one of which always stays
// empty, so it holds at most DEPTH-1 entries. Each request is a push, a pop or a dump, and
// the block answers with result items on the m_ channel, the final one marked by m_last.
// A push, and a pop or dump on an empty queue, gives one result with no memory read. A pop
// of a stored value passes through the registered read port of the slot memory. A dump
// reads one slot per cycle while the output register is free, one result per entry.
// Requests are handled one at a time, and a new one is taken once the output register is
// free or is being emptied in the same cycle. Opcode 3 is accepted and ignored.
module circular_fifo_queue
    import cfq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [31:0] s_push_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_data_out,
    output logic               m_last
);

    cfq_cmd_t cmd;
    cfq_sts_t sts;

    cfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_data_out   (m_data_out),
        .m_last       (m_last),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

[tb/sv/circular_fifo_queue_tb.sv]
`timescale 1ns / 1ps

module circular_fifo_queue_tb;
    import cfq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int AW = $clog2(DEPTH);
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } request_t;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } queue_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode = OP_PUSH;
    logic signed [31:0] s_push_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic signed [31:0] m_data_out;
    logic               m_last;

    request_t      pending_q[$];
    queue_result_t expected_q[$];

    logic signed [31:0] ring_mem [DEPTH];
    logic [AW-1:0]      head_ix = '0;
    logic [AW-1:0]      tail_ix = '0;

    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_len = 0;
    int          mismatches = 0;
    int unsigned quiet_cycles = 0;

    circular_fifo_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_push_value(s_push_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_data_out  (m_data_out),
        .m_last      (m_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [AW-1:0] ring_next(logic [AW-1:0] ix);
        return AW'((int'(ix) + 1) % DEPTH);
    endfunction

    function automatic void expect_result(logic [1:0] status, logic signed [31:0] data,
                                          logic last);
        queue_result_t res;
        res.status = status;
        res.data = data;
        res.last = last;
        expected_q.push_back(res);
    endfunction

    // Applies one request to the ring model and queues the results it causes.
    function automatic void predict_queue_results(logic [1:0] opcode, logic signed [31:0] value);
        logic [AW-1:0] ix;
        logic [AW-1:0] nxt;
        case (opcode)
            OP_PUSH: begin
                if (head_ix == ring_next(tail_ix)) begin
                    expect_result(ST_FULL, '0, 1'b1);
                end else begin
                    ring_mem[tail_ix] = value;
                    tail_ix = ring_next(tail_ix);
                    expect_result(ST_OK, '0, 1'b1);
                end
            end
            OP_POP: begin
                if (head_ix == tail_ix) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    expect_result(ST_OK, ring_mem[head_ix], 1'b1);
                    head_ix = ring_next(head_ix);
                end
            end
            OP_DUMP: begin
                if (head_ix == tail_ix) begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    ix = head_ix;
                    while (ix != tail_ix) begin
                        nxt = ring_next(ix);
                        expect_result(ST_OK, ring_mem[ix], nxt == tail_ix);
                        ix = nxt;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch on %s: got %h, want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_queue_results(s_opcode, s_push_value);
            end
            if (!s_valid || s_ready) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    req = pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_opcode <= req.opcode;
                    s_push_value <= req.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", m_data_out, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_status !== want.status) begin
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    end
                    if (m_data_out !== want.data) begin
                        report_mismatch("data_out", m_data_out, want.data);
                    end
                    if (m_last !== want.last) begin
                        report_mismatch("last", 32'(m_last), 32'(want.last));
                    end
                end
            end
            if (hold_len > 0) begin
                hold_len <= hold_len - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(0, 99) >= recv_idle;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(logic [1:0] opcode, logic signed [31:0] value);
        request_t req;
        req.opcode = opcode;
        req.value = value;
        pending_q.push_back(req);
    endtask

    task automatic add_random(int count, int push_pct, int pop_pct);
        int pick;
        logic [1:0] opcode;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct) begin
                opcode = OP_PUSH;
            end else if (pick < push_pct + pop_pct) begin
                opcode = OP_POP;
            end else if (pick < 95) begin
                opcode = OP_DUMP;
            end else begin
                opcode = OP_NONE;
            end
            add_request(opcode, pick_value());
        end
    endtask

    task automatic wait_all_sent();
        while (pending_q.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle = 24;
        recv_idle = 84;
        add_request(OP_POP, $urandom);
        add_request(OP_DUMP, $urandom);
        add_request(OP_NONE, $urandom);
        add_request(OP_PUSH, 32'sh7FFF_FFFF);
        add_request(OP_PUSH, 32'sh8000_0000);
        add_request(OP_PUSH, '0);
        add_request(OP_PUSH, -32'sd1);
        add_request(OP_PUSH, 32'shAAAA_AAAA);
        add_request(OP_PUSH, 32'sh5555_5555);
        add_request(OP_DUMP, '0);
        add_request(OP_POP, '0);
        add_request(OP_POP, '0);
        for (int k = 0; k < 12; k++) begin
            add_request(OP_PUSH, $urandom);
        end
        add_request(OP_DUMP, '0);
        add_random(20, 50, 30);
        wait_all_sent();

        send_idle = 84;
        recv_idle = 24;
        add_random(30, 35, 45);
        wait_all_sent();

        send_idle = 0;
        recv_idle = 0;
        hold_len = HOLD_CYCLES;
        for (int k = 0; k < 18; k++) begin
            add_request(OP_PUSH, pick_value());
        end
        add_request(OP_DUMP, '0);
        add_random(16, 40, 40);
        wait_all_sent();

        while (expected_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
